/* rtl/pae_pkg.sv */
// Shared types and constants for the polyphonic ADSR envelope.
// Used by pae_front, pae_back and polyphonic_adsr_envelope; depends on nothing.
`default_nettype none

package pae_pkg;

  // Segment codes
  localparam logic [2:0] SEG_SILENCE = 3'd0;
  localparam logic [2:0] SEG_ATTACK  = 3'd1;
  localparam logic [2:0] SEG_DECAY   = 3'd2;
  localparam logic [2:0] SEG_SUSTAIN = 3'd3;
  localparam logic [2:0] SEG_RELEASE = 3'd4;

  // Note events
  localparam logic [1:0] MODE_NONE    = 2'd0;
  localparam logic [1:0] MODE_START   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK    = 3'd4;

  localparam logic [15:0] LEVEL_ONE = 16'd32768;

  typedef struct packed {
    logic [3:0]         voice_index;
    logic               sounding;
    logic [1:0]         mode;
    logic               released;
    logic signed [23:0] sample_in;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         voice_out;
    logic signed [23:0] sample_out;
    logic               keep_alive;
    logic [15:0]        envelope_level;
  } out_item_t;

  // Queue entry: the item plus the front's classification
  typedef struct packed {
    in_item_t item;
    logic     vok;     // voice index below the voice count
    logic     active;  // vok and sounding
  } q_item_t;

  typedef struct packed {
    logic [23:0] attack_length;
    logic [23:0] decay_length;
    logic [23:0] release_length;
    logic [15:0] sustain_level;
    logic [15:0] peak_level;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [23:0]        total;
    logic signed [24:0] left;
    logic [15:0]        start;
    logic signed [16:0] delta;
    logic [15:0]        cur;
  } voice_st_t;

endpackage

`default_nettype wire

/* rtl/pae_front.sv */
// Front end: accepts input transfers, classifies them and queues them.
// Depends on pae_pkg.
`default_nettype none

module pae_front #(
  parameter int VOICES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pae_pkg::in_item_t in_data,
  output logic                   q_valid,
  output pae_pkg::q_item_t       q_data,
  input  wire logic              q_pop
);
  import pae_pkg::*;

  q_item_t    fifo_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  q_item_t    entry;

  // Classify the incoming item
  always_comb begin
    entry.item   = in_data;
    entry.vok    = (32'(in_data.voice_index) < VOICES);
    entry.active = entry.vok && in_data.sounding;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && q_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule

`default_nettype wire

/* rtl/pae_back.sv */
// Back end: per-voice state memory, segment sequencer, iterative progress
// divider, level^1.5 gain table and the output register. Depends on pae_pkg.
`default_nettype none

module pae_back #(
  parameter int VOICES         = 16,
  parameter int POW_TABLE_BITS = 10
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire pae_pkg::cfg_t      cfg,
  input  wire logic               q_valid,
  input  wire pae_pkg::q_item_t   q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output pae_pkg::out_item_t      out_data
);
  import pae_pkg::*;

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int TP = (1 << POW_TABLE_BITS) + 2;
  localparam int AW = POW_TABLE_BITS + 1;
  localparam int PW = 16 + POW_TABLE_BITS;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_READ  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_DIV   = 4'd3;
  localparam logic [3:0] ST_LEVEL = 4'd4;
  localparam logic [3:0] ST_GA    = 4'd5;
  localparam logic [3:0] ST_GB    = 4'd6;
  localparam logic [3:0] ST_GC    = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;
  localparam logic [3:0] ST_OUT   = 4'd9;

  typedef logic [15:0] tab_t [TP];

  // Gain table: isqrt(i^3) scaled so that point 2^POW_TABLE_BITS is 1.0 in Q1.15
  function automatic tab_t build_tab();
    tab_t            t;
    longint unsigned c, v, x, r, b;
    int              sh3;
    sh3 = 3 * POW_TABLE_BITS;
    for (int i = 0; i < TP; i++) begin
      c = longint'(i) * longint'(i) * longint'(i);
      if (sh3 >= 30) v = c >> (sh3 - 30);
      else v = c << (30 - sh3);
      x = v;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      t[i] = r[15:0];
    end
    return t;
  endfunction

  localparam tab_t GAIN_TAB = build_tab();

  function automatic logic [15:0] clamp_level(logic [15:0] v);
    return (v > LEVEL_ONE) ? LEVEL_ONE : v;
  endfunction

  function automatic logic is_moving(logic [2:0] k);
    return (k == SEG_ATTACK) || (k == SEG_DECAY) || (k == SEG_RELEASE);
  endfunction

  // State of a voice on entering a segment
  function automatic voice_st_t enter_seg(logic [2:0] kind, logic [23:0] len,
                                          logic [15:0] goal, logic [15:0] cur,
                                          logic [15:0] sus);
    voice_st_t s;
    s.kind  = kind;
    s.total = len;
    s.left  = $signed({1'b0, len});
    if (is_moving(kind)) begin
      s.start = cur;
      s.delta = $signed({1'b0, clamp_level(goal)}) - $signed({1'b0, cur});
      s.cur   = cur;
    end else begin
      s.start = 16'd0;
      s.delta = 17'sd0;
      s.cur   = (kind == SEG_SUSTAIN) ? clamp_level(sus) : 16'd0;
    end
    return s;
  endfunction

  voice_st_t          vmem [VOICES];
  logic [VOICES-1:0]  vvalid_r;
  voice_st_t          vrd_r;
  logic               vld_r;

  logic [3:0]         state_r, state_nxt;
  q_item_t            item_r;
  voice_st_t          w_r, w_nxt;
  logic               keep_r, keep_nxt;
  logic [16:0]        mag_r, mag_nxt;
  logic [24:0]        rem_r, rem_nxt;
  logic [16:0]        dlo_r, dlo_nxt;
  logic [4:0]         cnt_r, cnt_nxt;
  logic [15:0]        glev_r, glev_nxt;
  logic [15:0]        ga_r, ga_nxt;
  logic [15:0]        gain_r, gain_nxt;
  logic signed [23:0] res_r, res_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic [AW-1:0]      rom_addr;
  logic [15:0]        rom_q;
  logic [IW-1:0]      rd_idx, wr_idx;
  logic               can_load;

  // Working signals
  voice_st_t          vst, st_ev, st_adv;
  logic [24:0]        lc;
  logic [23:0]        el;
  logic [16:0]        dabs;
  logic [40:0]        prod;
  logic [24:0]        rtry;
  logic signed [18:0] lvl19;
  logic [15:0]        newcur;
  logic [PW-1:0]      gp;
  logic [AW-1:0]      gidx;
  logic [14:0]        gfrac;
  logic [15:0]        gdiff;
  logic [30:0]        gprod;
  logic [23:0]        sabs;
  logic [39:0]        sprod;
  logic [24:0]        smag;

  assign rd_idx   = IW'(q_data.item.voice_index);
  assign wr_idx   = IW'(item_r.item.voice_index);
  assign can_load = !out_valid_r || out_ready;
  assign q_pop    = (state_r == ST_IDLE) && q_valid;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Voice state memory: one read and one write port
  always_ff @(posedge clk) begin
    if (q_pop) begin
      vrd_r <= vmem[rd_idx];
      vld_r <= vvalid_r[rd_idx];
    end
    if (state_r == ST_OUT && can_load && item_r.active) begin
      vmem[wr_idx] <= w_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vvalid_r <= '0;
    end else if (state_r == ST_OUT && can_load && item_r.active) begin
      vvalid_r[wr_idx] <= 1'b1;
    end
  end

  // Gain table ROM, registered read
  always_ff @(posedge clk) begin
    rom_q <= GAIN_TAB[rom_addr];
  end

  // Gain lookup index and fraction
  always_comb begin
    gp       = {glev_r, {POW_TABLE_BITS{1'b0}}};
    gidx     = gp[PW-1:15];
    gfrac    = gp[14:0];
    rom_addr = (state_r == ST_GB) ? gidx + AW'(1) : gidx;
  end

  // Event application and segment advance
  always_comb begin
    vst = vld_r ? vrd_r : '0;
    priority case (1'b1)
      item_r.item.mode == MODE_START:
        st_ev = enter_seg(SEG_ATTACK, cfg.attack_length, cfg.peak_level, vst.cur,
                          cfg.sustain_level);
      item_r.item.mode == MODE_RELEASE:
        st_ev = enter_seg(SEG_RELEASE, cfg.release_length, 16'd0, vst.cur,
                          cfg.sustain_level);
      default: st_ev = vst;
    endcase

    // Elapsed samples and product for the progress division
    lc = w_r.left[24] ? 25'd0 : w_r.left;
    if (lc > {1'b0, w_r.total}) lc = {1'b0, w_r.total};
    el   = w_r.total - lc[23:0];
    dabs = w_r.delta[16] ? 17'(-w_r.delta) : w_r.delta;
    prod = 41'(dabs) * 41'(el);
    rtry = {rem_r[23:0], dlo_r[16]};

    // New level, clamped to [0, 1.0]
    if (w_r.delta[16]) lvl19 = $signed({3'b0, w_r.start}) - $signed({2'b0, mag_r});
    else lvl19 = $signed({3'b0, w_r.start}) + $signed({2'b0, mag_r});
    if (lvl19 < 0) newcur = 16'd0;
    else if (lvl19 > $signed({3'b0, LEVEL_ONE})) newcur = LEVEL_ONE;
    else newcur = lvl19[15:0];

    st_adv      = w_r;
    st_adv.cur  = newcur;
    st_adv.left = w_r.left - 25'sd1;
    if (st_adv.left <= 0) begin
      unique case (w_r.kind)
        SEG_ATTACK: begin
          st_adv = enter_seg(SEG_DECAY, cfg.decay_length, cfg.sustain_level, newcur,
                             cfg.sustain_level);
          if (st_adv.left <= 0) begin
            st_adv = enter_seg(SEG_SUSTAIN, 24'd0, 16'd0, newcur, cfg.sustain_level);
          end
        end
        SEG_DECAY:
          st_adv = enter_seg(SEG_SUSTAIN, 24'd0, 16'd0, newcur, cfg.sustain_level);
        default:
          st_adv = enter_seg(SEG_SILENCE, 24'd0, 16'd0, newcur, cfg.sustain_level);
      endcase
    end

    gdiff = rom_q - ga_r;
    gprod = 31'(gdiff) * 31'(gfrac);
    sabs  = item_r.item.sample_in[23] ? 24'(-item_r.item.sample_in)
                                      : item_r.item.sample_in;
    sprod = 40'(sabs) * 40'(gain_r);
    smag  = sprod[39:15];
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    w_nxt     = w_r;
    keep_nxt  = keep_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    dlo_nxt   = dlo_r;
    cnt_nxt   = cnt_r;
    glev_nxt  = glev_r;
    ga_nxt    = ga_r;
    gain_nxt  = gain_r;
    res_nxt   = res_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        if (item_r.active) begin
          w_nxt    = st_ev;
          keep_nxt = item_r.item.released && (st_ev.kind == SEG_RELEASE);
          glev_nxt = clamp_level(st_ev.cur);
          state_nxt = is_moving(st_ev.kind) ? ST_MUL : ST_GA;
        end else begin
          w_nxt     = vst;
          keep_nxt  = 1'b0;
          res_nxt   = item_r.item.sample_in;
          state_nxt = ST_OUT;
        end
      end
      ST_MUL: begin
        if (w_r.total == 24'd0) begin
          mag_nxt   = dabs;
          state_nxt = ST_LEVEL;
        end else begin
          mag_nxt   = 17'd0;
          rem_nxt   = {1'b0, prod[40:17]};
          dlo_nxt   = prod[16:0];
          cnt_nxt   = 5'd0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle
        if (rtry >= {1'b0, w_r.total}) begin
          rem_nxt = rtry - {1'b0, w_r.total};
          mag_nxt = {mag_r[15:0], 1'b1};
        end else begin
          rem_nxt = rtry;
          mag_nxt = {mag_r[15:0], 1'b0};
        end
        dlo_nxt = {dlo_r[15:0], 1'b0};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd16) state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        glev_nxt  = newcur;
        w_nxt     = st_adv;
        state_nxt = ST_GA;
      end
      ST_GA: state_nxt = ST_GB;
      ST_GB: begin
        ga_nxt    = rom_q;
        state_nxt = ST_GC;
      end
      ST_GC: begin
        gain_nxt  = (gfrac == 15'd0) ? ga_r : ga_r + gprod[30:15];
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        res_nxt   = item_r.item.sample_in[23] ? 24'(-smag) : smag[23:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (can_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (q_pop) item_r <= q_data;
    w_r    <= w_nxt;
    keep_r <= keep_nxt;
    mag_r  <= mag_nxt;
    rem_r  <= rem_nxt;
    dlo_r  <= dlo_nxt;
    cnt_r  <= cnt_nxt;
    glev_r <= glev_nxt;
    ga_r   <= ga_nxt;
    gain_r <= gain_nxt;
    res_r  <= res_nxt;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && can_load) begin
      out_data_r.voice_out      <= item_r.item.voice_index;
      out_data_r.sample_out     <= res_r;
      out_data_r.keep_alive     <= keep_r;
      out_data_r.envelope_level <= item_r.vok ? w_r.cur : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_OUT && can_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* rtl/polyphonic_adsr_envelope.sv */
// Polyphonic linear ADSR envelope: top level with configuration registers.
// An item passes the two-entry input queue, then the back end's read, multiply, progress
// divider (one quotient bit per cycle), level, gain lookup, scale and output states. A
// zero-length segment skips the divider, silence or sustain go from read to gain lookup,
// and an item that is not sounding goes from read to output. The back end holds one item at
// a time until it enters the output register, which an output stall delays; the queue takes
// new transfers meanwhile. Synchronous active-low reset clears all voices to silence and
// loads the default segment settings. Depends on pae_pkg, pae_front and pae_back.
`default_nettype none

module polyphonic_adsr_envelope #(
  parameter int VOICES         = 16,
  parameter int POW_TABLE_BITS = 10
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire pae_pkg::in_item_t               in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output pae_pkg::out_item_t                   out_data,
  input  wire logic                            cfg_we,
  input  wire logic [pae_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pae_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import pae_pkg::*;

  cfg_t    cfg_r;
  logic    q_valid, q_pop;
  q_item_t q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_length  <= 24'd480;
      cfg_r.decay_length   <= 24'd4800;
      cfg_r.release_length <= 24'd4800;
      cfg_r.sustain_level  <= 16'd16384;
      cfg_r.peak_level     <= 16'd32768;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK:  cfg_r.attack_length  <= cfg_data;
        CFG_DECAY:   cfg_r.decay_length   <= cfg_data;
        CFG_RELEASE: cfg_r.release_length <= cfg_data;
        CFG_SUSTAIN: cfg_r.sustain_level  <= cfg_data[15:0];
        CFG_PEAK:    cfg_r.peak_level     <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  pae_front #(.VOICES(VOICES)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop)
  );

  pae_back #(.VOICES(VOICES), .POW_TABLE_BITS(POW_TABLE_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
